### rtl/core/b2da_pkg.sv
package b2da_pkg;

   // width of the binary number
   localparam int VALUE_BITS = 32;
   // decimal digits of 2^VALUE_BITS - 1 (1233 / 4096 ~ log10(2))
   localparam int DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int BCD_BITS = DIGITS * 4;
   localparam int BIT_CNT_BITS = $clog2(VALUE_BITS + 1);
   localparam int DIG_CNT_BITS = $clog2(DIGITS + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [5:0] ASCII_ZERO = 6'd48;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  is_zero;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } back_state_type;

   // add 3 to every bcd digit of 5 or more
   function automatic logic [BCD_BITS-1:0] dabble_adjust(input logic [BCD_BITS-1:0] bcd);
      logic [BCD_BITS-1:0] res;
      res = bcd;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd[i*4 +: 4] >= 4'd5) begin
            res[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
         end
      end
      return res;
   endfunction

endpackage

### rtl/core/b2da_front.sv
module b2da_front
   import b2da_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  req_full,
   output logic                  item_valid,
   output item_type              item,
   input  logic                  item_ready
);

   logic     hold_valid_ff, hold_valid_in;
   item_type hold_ff;
   logic     accept;
   logic     move;

   assign move       = hold_valid_ff && item_ready;
   assign req_full   = hold_valid_ff && !item_ready;
   assign accept     = req_push && !req_full;
   assign item_valid = hold_valid_ff;
   assign item       = hold_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (move) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   // classify on the way in: zero takes the short path
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff.value   <= req_value;
         hold_ff.is_zero <= (req_value == '0);
      end
   end

endmodule

### rtl/core/b2da_queue.sv
module b2da_queue
   import b2da_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   input  item_type wr_item,
   output logic     wr_ready,
   output logic     rd_valid,
   output item_type rd_item,
   input  logic     rd_ready
);

   item_type             store_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_wr;
   logic                 do_rd;

   assign wr_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_item  = store_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

### rtl/core/b2da_back.sv
module b2da_back
   import b2da_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_ready,
   output logic       rsp_empty,
   output logic [5:0] rsp_digit_char,
   output logic       rsp_last,
   input  logic       rsp_pop
);

   back_state_type          state_ff, state_in;
   logic [BCD_BITS-1:0]     bcd_ff, bcd_in;
   logic [VALUE_BITS-1:0]   shift_ff, shift_in;
   logic [BIT_CNT_BITS-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_BITS-1:0] dig_cnt_ff, dig_cnt_in;
   logic                    out_valid_ff, out_valid_in;
   logic [5:0]              out_char_ff, out_char_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_free;
   logic                    load;
   logic [BCD_BITS-1:0]     adj;
   logic [3:0]              top_digit;

   assign out_free       = !out_valid_ff || rsp_pop;
   assign top_digit      = bcd_ff[BCD_BITS-1 -: 4];
   assign adj            = dabble_adjust(bcd_ff);
   assign rsp_empty      = !out_valid_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_last       = out_last_ff;

   always_comb begin
      state_in    = state_ff;
      bcd_in      = bcd_ff;
      shift_in    = shift_ff;
      bit_cnt_in  = bit_cnt_ff;
      dig_cnt_in  = dig_cnt_ff;
      out_char_in = out_char_ff;
      out_last_in = out_last_ff;
      item_ready  = 1'b0;
      load        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               bcd_in = '0;
               if (item.is_zero) begin
                  dig_cnt_in = DIG_CNT_BITS'(1);
                  state_in   = ST_EMIT;
               end else begin
                  shift_in   = item.value;
                  bit_cnt_in = BIT_CNT_BITS'(VALUE_BITS);
                  state_in   = ST_CONVERT;
               end
            end
         end
         ST_CONVERT: begin
            bcd_in     = {adj[BCD_BITS-2:0], shift_ff[VALUE_BITS-1]};
            shift_in   = {shift_ff[VALUE_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == BIT_CNT_BITS'(1)) begin
               dig_cnt_in = DIG_CNT_BITS'(DIGITS);
               state_in   = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, one digit a cycle
            if (top_digit == 4'd0 && dig_cnt_ff != DIG_CNT_BITS'(1)) begin
               bcd_in     = {bcd_ff[BCD_BITS-5:0], 4'd0};
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load        = 1'b1;
               out_char_in = ASCII_ZERO + {2'b00, top_digit};
               out_last_in = (dig_cnt_ff == DIG_CNT_BITS'(1));
               bcd_in      = {bcd_ff[BCD_BITS-5:0], 4'd0};
               dig_cnt_in  = dig_cnt_ff - 1'b1;
               if (dig_cnt_ff == DIG_CNT_BITS'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff      <= bcd_in;
      shift_ff    <= shift_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   a_convert_cnt : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONVERT |-> bit_cnt_ff != '0)
      else $error("bit counter ran out during conversion");

   a_emit_cnt : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> dig_cnt_ff != '0)
      else $error("digit counter ran out during emission");

   a_emit_digit : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> top_digit <= 4'd9)
      else $error("bcd digit out of range");

   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      load && out_last_in |=> state_ff == ST_IDLE)
      else $error("run did not end after last digit");

   a_no_skip_past : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SKIP && top_digit != 4'd0 |=> state_ff == ST_EMIT)
      else $error("nonzero leading digit was skipped");

endmodule

### rtl/core/binary_to_decimal_ascii_top.sv
// channel      | ports                                   | transaction moves
// -------------+-----------------------------------------+-------------------------------
// request      | req_push, req_full, req_value           | one 32-bit unsigned number
// response     | rsp_pop, rsp_empty, rsp_digit_char,     | one ascii digit, msd first,
//              | rsp_last                                | rsp_last on the final digit
//
// a nonzero number takes the back end through accept, one double-dabble shift per input bit,
// one skip step per leading zero and a final skip check, then one digit per free output slot
// zero skips conversion: the back end goes from idle straight to emit and sends '0'
// synchronous active-high reset clears front register, queue, state machine and output valid
// the front register and a 2-entry queue keep taking numbers while the back end works
// a stalled rsp_pop holds the current digit and stops emission only
module binary_to_decimal_ascii_top
   import b2da_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request queue side
   input  logic                  req_push,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  req_full,
   // response queue side
   output logic                  rsp_empty,
   output logic [5:0]            rsp_digit_char,
   output logic                  rsp_last,
   input  logic                  rsp_pop
);

   // front register to queue
   logic     fr_valid;
   item_type fr_item;
   logic     fr_ready;

   // queue to back end
   logic     q_valid;
   item_type q_item;
   logic     q_ready;

   // front: captures the number and flags zero
   b2da_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_value  (req_value),
      .req_full   (req_full),
      .item_valid (fr_valid),
      .item       (fr_item),
      .item_ready (fr_ready)
   );

   // short queue decoupling intake from conversion
   b2da_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fr_valid),
      .wr_item  (fr_item),
      .wr_ready (fr_ready),
      .rd_valid (q_valid),
      .rd_item  (q_item),
      .rd_ready (q_ready)
   );

   // back: iterative double dabble, leading-zero skip, digit emission
   b2da_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (q_valid),
      .item           (q_item),
      .item_ready     (q_ready),
      .rsp_empty      (rsp_empty),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_pop        (rsp_pop)
   );

endmodule
